>>> sv/sbr_pkg.sv
// Shared types, widths and codes of the stack blur row pass.
`default_nettype none

package sbr_pkg;

   // Pixel format and limits.
   localparam int unsigned CHANNELS     = 4;
   localparam int unsigned CHANNEL_BITS = 8;
   localparam int unsigned MAX_RADIUS   = 63;
   localparam int unsigned MAX_WIDTH    = 4096;
   localparam int unsigned RING_DEPTH   = 2 * MAX_RADIUS + 1;
   localparam int unsigned PIX_W        = CHANNELS * CHANNEL_BITS;

   // Field and register widths.
   localparam int unsigned RAD_W   = 6;
   localparam int unsigned COL_W   = 13;
   localparam int unsigned PTR_W   = 7;
   localparam int unsigned WSUM_W  = 20;
   localparam int unsigned SUM_W   = 14;
   localparam int unsigned DIV_W   = 13;
   localparam int unsigned FACT_W  = 12;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned STEP_W  = 3;

   typedef logic [CHANNEL_BITS-1:0]              chan_type;
   typedef logic [CHANNELS-1:0][CHANNEL_BITS-1:0] chan_vec_type;
   typedef logic [CHANNELS-1:0][WSUM_W-1:0]       wsum_vec_type;
   typedef logic [CHANNELS-1:0][SUM_W-1:0]        sum_vec_type;
   typedef logic [DIV_W-1:0]                      div_type;
   typedef logic [CSR_IDX_W-1:0]                  csr_idx_type;
   typedef logic [COL_W-1:0]                      csr_data_type;

   // Register indexes of the configuration port.
   localparam csr_idx_type CSR_BLUR_RADIUS = csr_idx_type'(0);
   localparam csr_idx_type CSR_ROW_WIDTH   = csr_idx_type'(1);

   // Sequencer states.
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_DECIDE = 10'b00_0000_0010,
      ST_MUL    = 10'b00_0000_0100,
      ST_ACC    = 10'b00_0000_1000,
      ST_RD_OLD = 10'b00_0001_0000,
      ST_RD_MID = 10'b00_0010_0000,
      ST_UPD    = 10'b00_0100_0000,
      ST_DIV_LD = 10'b00_1000_0000,
      ST_DIV    = 10'b01_0000_0000,
      ST_OUT    = 10'b10_0000_0000
   } state_type;

endpackage

`default_nettype wire

>>> sv/sbr_if.sv
// Handshake channels of the stack blur row pass: pixel in, blurred pixel out, register write.
`default_nettype none

interface sbr_req_if;
   logic              valid;
   logic              ready;
   sbr_pkg::chan_type chan_a;
   sbr_pkg::chan_type chan_b;
   sbr_pkg::chan_type chan_c;
   sbr_pkg::chan_type chan_d;
   modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
   modport sink   (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

interface sbr_rsp_if;
   logic              valid;
   logic              ready;
   sbr_pkg::chan_type blur_a;
   sbr_pkg::chan_type blur_b;
   sbr_pkg::chan_type blur_c;
   sbr_pkg::chan_type blur_d;
   logic              row_end;
   logic              run_end;
   modport source (output valid, blur_a, blur_b, blur_c, blur_d, row_end, run_end,
                   input ready);
   modport sink   (input valid, blur_a, blur_b, blur_c, blur_d, row_end, run_end,
                   output ready);
endinterface

interface sbr_csr_if;
   logic                  valid;
   logic                  ready;
   sbr_pkg::csr_idx_type  index;
   sbr_pkg::csr_data_type data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/sbr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sbr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/sbr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, all channels side by side.
`default_nettype none

module sbr_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire sbr_pkg::wsum_vec_type dividend,
   input  wire sbr_pkg::div_type      divisor,
   output sbr_pkg::chan_vec_type      quotient,
   output logic                       done
);

   sbr_pkg::wsum_vec_type rem_ff, rem_in;
   sbr_pkg::chan_vec_type q_ff, q_in;
   logic [sbr_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [sbr_pkg::WSUM_W:0] shifted;

   // The divisor is aligned to the quotient bit under test.
   assign shifted = (sbr_pkg::WSUM_W + 1)'(divisor) << cnt_ff;

   // One compare and subtract per channel per cycle.
   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (load) begin
         rem_in  = dividend;
         q_in    = '0;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < sbr_pkg::CHANNELS; i++) begin
            if ({1'b0, rem_ff[i]} >= shifted) begin
               rem_in[i] = rem_ff[i] - shifted[sbr_pkg::WSUM_W-1:0];
               q_in[i]   = {q_ff[i][sbr_pkg::CHANNEL_BITS-2:0], 1'b1};
            end else begin
               q_in[i]   = {q_ff[i][sbr_pkg::CHANNEL_BITS-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = q_ff;
   assign done     = busy_ff && (cnt_ff == '0);

endmodule

`default_nettype wire

>>> sv/stack_blur_row_pass_unit.sv
// Top level of the horizontal stack blur pass over one pixel row.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    chan_a..chan_d, one pixel
//   rsp_chan  out        valid/ready    blur_a..blur_d, row_end, run_end
//   csr_chan  in         valid/ready    index, data (0: blur_radius, 1: row_width)
//
// Steps per req transfer, without stalls: decide, then multiply and accumulate up to column r
// (twice at column 0), adding at column r a divider load, the division and the output; past
// it, two ring reads, a sum update, a divider load, the division and the output. The last
// pixel of a row repeats the steps from the ring reads on for each of its r further results.
// Synchronous active-high reset; no clearing pass, the ring is written before it is read.
// Both req and csr stall while an item is in work; a stalled result holds its register.
`default_nettype none

module stack_blur_row_pass_unit (
   input wire logic clock,
   input wire logic reset,
   sbr_req_if.sink   req_chan,
   sbr_rsp_if.source rsp_chan,
   sbr_csr_if.sink   csr_chan
);

   sbr_pkg::state_type state_ff, state_in;

   logic [sbr_pkg::RAD_W-1:0]  radius_ff;
   logic [sbr_pkg::COL_W-1:0]  width_ff;

   // Effective values derived from the registers.
   logic [sbr_pkg::COL_W-1:0]  w_eff;
   logic [sbr_pkg::COL_W-2:0]  half_w;
   logic [sbr_pkg::RAD_W-1:0]  r_eff;
   logic [sbr_pkg::RAD_W:0]    rp1_eff;
   logic [sbr_pkg::RAD_W-1:0]  r_ff;
   logic [sbr_pkg::COL_W-1:0]  w_ff;
   sbr_pkg::div_type           d_ff;
   logic [sbr_pkg::FACT_W-1:0] tri_ff;
   logic [2*sbr_pkg::RAD_W+1:0] d_full;
   logic [2*sbr_pkg::RAD_W+2:0] tri_full;

   // Row state.
   logic [sbr_pkg::COL_W-1:0] c_ff, c_in;
   logic [sbr_pkg::COL_W-1:0] oc_ff, oc_in;
   logic [sbr_pkg::PTR_W-1:0] p_ff, p_in;
   logic lap_ff, lap_in;
   logic ph_ff, ph_in;
   sbr_pkg::chan_vec_type v_ff, v_in;
   sbr_pkg::chan_vec_type v0_ff, v0_in;
   sbr_pkg::chan_vec_type old_ff, old_in;
   sbr_pkg::wsum_vec_type sw_ff, sw_in;
   sbr_pkg::sum_vec_type  so_ff, so_in;
   sbr_pkg::sum_vec_type  si_ff, si_in;
   sbr_pkg::wsum_vec_type prod_ff, prod_in;
   logic row_end_ff, row_end_in;
   logic run_end_ff, run_end_in;

   // Ring, multiplier and divider hookup.
   logic                      ram_we, ram_re;
   logic [sbr_pkg::PTR_W-1:0] ram_wa, ram_ra;
   logic [sbr_pkg::PIX_W-1:0] ram_rd;
   sbr_pkg::chan_vec_type     ram_pix;
   sbr_pkg::chan_vec_type     old_sel, mid_sel;
   logic [sbr_pkg::FACT_W-1:0] factor;
   logic [sbr_pkg::RAD_W:0]   ring_k;
   logic [sbr_pkg::PTR_W:0]   nx_sum;
   logic [sbr_pkg::PTR_W-1:0] nx;
   logic                      div_load, div_done;
   sbr_pkg::chan_vec_type     quot;

   logic req_fire, rsp_fire, csr_fire, cfg_restart;
   logic c_is0, c_le_r, c_eq_r, last_col, at_row_end;

   // Handshakes: configuration has priority while idle.
   assign csr_chan.ready = (state_ff == sbr_pkg::ST_IDLE);
   assign req_chan.ready = (state_ff == sbr_pkg::ST_IDLE) && !csr_chan.valid;
   assign rsp_chan.valid = (state_ff == sbr_pkg::ST_OUT);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign cfg_restart = csr_fire && ((csr_chan.index == sbr_pkg::CSR_BLUR_RADIUS) ||
                                     (csr_chan.index == sbr_pkg::CSR_ROW_WIDTH));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= sbr_pkg::RAD_W'(1);
         width_ff  <= sbr_pkg::COL_W'(1);
      end else if (csr_fire) begin
         case (csr_chan.index)
            sbr_pkg::CSR_BLUR_RADIUS: radius_ff <= csr_chan.data[sbr_pkg::RAD_W-1:0];
            sbr_pkg::CSR_ROW_WIDTH:   width_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Width saturates to the row limit and a zero width counts as 1; radius is capped at (width-1)/2.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = sbr_pkg::COL_W'(1);
      end else if (width_ff > sbr_pkg::COL_W'(sbr_pkg::MAX_WIDTH)) begin
         w_eff = sbr_pkg::COL_W'(sbr_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      half_w = (sbr_pkg::COL_W-1)'((w_eff - 1'b1) >> 1);
      if ((sbr_pkg::COL_W-1)'(radius_ff) > half_w) begin
         r_eff = half_w[sbr_pkg::RAD_W-1:0];
      end else begin
         r_eff = radius_ff;
      end
      rp1_eff  = {1'b0, r_eff} + 1'b1;
      d_full   = rp1_eff * rp1_eff;
      tri_full = (2*sbr_pkg::RAD_W+3)'(rp1_eff) * (2*sbr_pkg::RAD_W+3)'(rp1_eff + 1'b1);
   end

   // Divisor (r+1)^2 and the first-pixel weight (r+1)(r+2)/2, registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff   <= '0;
         w_ff   <= sbr_pkg::COL_W'(1);
         d_ff   <= sbr_pkg::DIV_W'(1);
         tri_ff <= sbr_pkg::FACT_W'(1);
      end else begin
         r_ff   <= r_eff;
         w_ff   <= w_eff;
         d_ff   <= d_full[sbr_pkg::DIV_W-1:0];
         tri_ff <= tri_full[sbr_pkg::FACT_W:1];
      end
   end

   // Column tests.
   assign c_is0      = (c_ff == '0);
   assign c_le_r     = (c_ff <= sbr_pkg::COL_W'(r_ff));
   assign c_eq_r     = (c_ff == sbr_pkg::COL_W'(r_ff));
   assign last_col   = (c_ff >= w_ff - 1'b1);
   assign at_row_end = (oc_ff == w_ff - 1'b1);

   // Ring geometry: k = 2r+1, the entering-middle entry sits r+1 past the pointer.
   assign ring_k = {r_ff, 1'b1};
   assign nx_sum = {1'b0, p_ff} + sbr_pkg::PTR_W'(r_ff) + 1'b1;
   assign nx     = (nx_sum >= (sbr_pkg::PTR_W+1)'(ring_k)) ?
                   sbr_pkg::PTR_W'(nx_sum - (sbr_pkg::PTR_W+1)'(ring_k)) :
                   nx_sum[sbr_pkg::PTR_W-1:0];
   assign ram_pix = ram_rd;

   // On the first lap the left half of the ring is not yet written; the clamped first pixel stands in.
   always_comb begin
      for (int i = 0; i < sbr_pkg::CHANNELS; i++) begin
         old_sel[i] = (lap_ff && (p_ff <= sbr_pkg::PTR_W'(r_ff))) ? v0_ff[i] : old_ff[i];
         mid_sel[i] = (r_ff == '0) ? v_ff[i] : ram_pix[i];
      end
   end

   function automatic logic [sbr_pkg::RAD_W:0] rp1_eff_reg();
      return {1'b0, r_ff} + 1'b1;
   endfunction

   // Multiplier factor: (r+1) then (r+1)(r+2)/2 for the first pixel, r+1-c after.
   always_comb begin
      if (c_is0) begin
         factor = ph_ff ? tri_ff : sbr_pkg::FACT_W'(rp1_eff_reg());
      end else begin
         factor = sbr_pkg::FACT_W'({1'b0, r_ff} + 1'b1 - {1'b0, c_ff[sbr_pkg::RAD_W-1:0]});
      end
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      c_in       = c_ff;
      oc_in      = oc_ff;
      p_in       = p_ff;
      lap_in     = lap_ff;
      ph_in      = ph_ff;
      v_in       = v_ff;
      v0_in      = v0_ff;
      old_in     = old_ff;
      sw_in      = sw_ff;
      so_in      = so_ff;
      si_in      = si_ff;
      prod_in    = prod_ff;
      row_end_in = row_end_ff;
      run_end_in = run_end_ff;
      ram_we     = 1'b0;
      ram_wa     = p_ff;
      ram_re     = 1'b0;
      ram_ra     = p_ff;
      div_load   = 1'b0;

      case (state_ff)
         sbr_pkg::ST_IDLE: begin
            if (req_fire) begin
               v_in[0]  = req_chan.chan_a;
               v_in[1]  = req_chan.chan_b;
               v_in[2]  = req_chan.chan_c;
               v_in[3]  = req_chan.chan_d;
               state_in = sbr_pkg::ST_DECIDE;
            end
         end
         sbr_pkg::ST_DECIDE: begin
            if (c_is0) begin
               v0_in    = v_ff;
               ph_in    = 1'b0;
               state_in = sbr_pkg::ST_MUL;
            end else if (c_le_r) begin
               state_in = sbr_pkg::ST_MUL;
            end else begin
               state_in = sbr_pkg::ST_RD_OLD;
            end
         end
         sbr_pkg::ST_MUL: begin
            for (int i = 0; i < sbr_pkg::CHANNELS; i++) begin
               prod_in[i] = sbr_pkg::WSUM_W'(factor) * sbr_pkg::WSUM_W'(v_ff[i]);
            end
            state_in = sbr_pkg::ST_ACC;
         end
         sbr_pkg::ST_ACC: begin
            if (c_is0 && !ph_ff) begin
               // Left half plus center: r+1 copies of the first pixel.
               for (int i = 0; i < sbr_pkg::CHANNELS; i++) begin
                  so_in[i] = prod_ff[i][sbr_pkg::SUM_W-1:0];
               end
               ph_in    = 1'b1;
               state_in = sbr_pkg::ST_MUL;
            end else begin
               if (c_is0) begin
                  sw_in = prod_ff;
                  si_in = '0;
               end else begin
                  for (int i = 0; i < sbr_pkg::CHANNELS; i++) begin
                     sw_in[i] = sw_ff[i] + prod_ff[i];
                     si_in[i] = si_ff[i] + sbr_pkg::SUM_W'(v_ff[i]);
                  end
                  ram_we = 1'b1;
                  ram_wa = c_ff[sbr_pkg::PTR_W-1:0] + sbr_pkg::PTR_W'(r_ff);
               end
               if (c_eq_r) begin
                  state_in = sbr_pkg::ST_DIV_LD;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = sbr_pkg::ST_IDLE;
               end
            end
         end
         sbr_pkg::ST_RD_OLD: begin
            ram_re   = 1'b1;
            ram_ra   = p_ff;
            state_in = sbr_pkg::ST_RD_MID;
         end
         sbr_pkg::ST_RD_MID: begin
            ram_re   = 1'b1;
            ram_ra   = nx;
            old_in   = ram_pix;
            state_in = sbr_pkg::ST_UPD;
         end
         sbr_pkg::ST_UPD: begin
            // Slide the window one pixel right.
            for (int i = 0; i < sbr_pkg::CHANNELS; i++) begin
               sw_in[i] = sw_ff[i] - sbr_pkg::WSUM_W'(so_ff[i]) + sbr_pkg::WSUM_W'(si_ff[i])
                          + sbr_pkg::WSUM_W'(v_ff[i]);
               so_in[i] = so_ff[i] - sbr_pkg::SUM_W'(old_sel[i]) + sbr_pkg::SUM_W'(mid_sel[i]);
               si_in[i] = si_ff[i] + sbr_pkg::SUM_W'(v_ff[i]) - sbr_pkg::SUM_W'(mid_sel[i]);
            end
            ram_we = 1'b1;
            ram_wa = p_ff;
            if ({1'b0, p_ff} + 1'b1 == (sbr_pkg::PTR_W+1)'(ring_k)) begin
               p_in   = '0;
               lap_in = 1'b0;
            end else begin
               p_in   = p_ff + 1'b1;
            end
            state_in = sbr_pkg::ST_DIV_LD;
         end
         sbr_pkg::ST_DIV_LD: begin
            div_load   = 1'b1;
            row_end_in = at_row_end;
            run_end_in = !last_col || at_row_end;
            state_in   = sbr_pkg::ST_DIV;
         end
         sbr_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = sbr_pkg::ST_OUT;
            end
         end
         sbr_pkg::ST_OUT: begin
            if (rsp_fire) begin
               oc_in = oc_ff + 1'b1;
               if (last_col && !row_end_ff) begin
                  state_in = sbr_pkg::ST_RD_OLD;
               end else if (last_col) begin
                  c_in     = '0;
                  oc_in    = '0;
                  p_in     = '0;
                  lap_in   = 1'b1;
                  state_in = sbr_pkg::ST_IDLE;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = sbr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sbr_pkg::ST_IDLE;
         end
      endcase

      // A register write starts a new row.
      if (cfg_restart) begin
         c_in   = '0;
         oc_in  = '0;
         p_in   = '0;
         lap_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbr_pkg::ST_IDLE;
         c_ff     <= '0;
         oc_ff    <= '0;
         p_ff     <= '0;
         lap_ff   <= 1'b1;
         ph_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         c_ff     <= c_in;
         oc_ff    <= oc_in;
         p_ff     <= p_in;
         lap_ff   <= lap_in;
         ph_ff    <= ph_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      v0_ff      <= v0_in;
      old_ff     <= old_in;
      sw_ff      <= sw_in;
      so_ff      <= so_in;
      si_ff      <= si_in;
      prod_ff    <= prod_in;
      row_end_ff <= row_end_in;
      run_end_ff <= run_end_in;
   end

   // Pixel ring of the 2r+1 window pixels.
   sbr_ram #(
      .WIDTH (sbr_pkg::PIX_W),
      .DEPTH (sbr_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (v_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Weighted sum over (r+1)^2.
   sbr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (sw_ff),
      .divisor  (d_ff),
      .quotient (quot),
      .done     (div_done)
   );

   // Result register.
   assign rsp_chan.blur_a  = quot[0];
   assign rsp_chan.blur_b  = quot[1];
   assign rsp_chan.blur_c  = quot[2];
   assign rsp_chan.blur_d  = quot[3];
   assign rsp_chan.row_end = row_end_ff;
   assign rsp_chan.run_end = run_end_ff;

   // Checks.
   a_no_accept_while_result: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid)
      else $error("input accepted while a result is pending");

   a_out_col_bound: assert property (@(posedge clock) disable iff (reset)
      oc_ff <= w_ff)
      else $error("output column ran past the row");

   a_ring_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      p_ff <= sbr_pkg::PTR_W'({r_ff, 1'b0}))
      else $error("ring pointer outside the window");

   a_row_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.row_end) |-> rsp_chan.run_end)
      else $error("row end without run end");

endmodule

`default_nettype wire

>>> dv/sbr_tb_if.sv
// Testbench note: the channel interfaces come from the RTL file sv/sbr_if.sv; this file holds the shared pixel record.
`default_nettype none

package sbr_tb_pkg;

   // One blurred pixel as it leaves the block.
   typedef struct packed {
      sbr_pkg::chan_type blur_a;
      sbr_pkg::chan_type blur_b;
      sbr_pkg::chan_type blur_c;
      sbr_pkg::chan_type blur_d;
      logic              row_end;
      logic              run_end;
   } blurred_pixel_type;
endpackage

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench of the stack blur row pass with its own row blur predictor.
`default_nettype none

module tb;

   logic clock;
   logic reset;

   sbr_req_if req_chan ();
   sbr_rsp_if rsp_chan ();
   sbr_csr_if csr_chan ();

   stack_blur_row_pass_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   // Predictor state: registers and row blur state.
   int unsigned radius_reg;
   int unsigned width_reg;
   int unsigned ring [sbr_pkg::RING_DEPTH][4];
   int unsigned wsum [4];
   int unsigned insum [4];
   int unsigned outsum [4];
   int unsigned ring_ptr;
   int unsigned in_col;
   int unsigned out_col;

   sbr_tb_pkg::blurred_pixel_type blurred_queue [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          rsp_stall_on;
   bit          sender_gaps_on;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int unsigned row_width_eff();
      if (width_reg == 0) return 1;
      if (width_reg > sbr_pkg::MAX_WIDTH) return sbr_pkg::MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned radius_eff(int unsigned w);
      int unsigned r;
      r = radius_reg;
      if (r > sbr_pkg::MAX_RADIUS) r = sbr_pkg::MAX_RADIUS;
      if (r > (w - 1) / 2) r = (w - 1) / 2;
      return r;
   endfunction

   function automatic void clear_row();
      for (int ch = 0; ch < 4; ch++) begin
         wsum[ch] = 0;
         insum[ch] = 0;
         outsum[ch] = 0;
      end
      ring_ptr = 0;
      in_col = 0;
      out_col = 0;
   endfunction

   // Slide the window one pixel right with px entering.
   function automatic void slide_window(int unsigned px [4], int unsigned r);
      int unsigned k;
      int unsigned p;
      int unsigned nx;
      int unsigned old;
      int unsigned mid;
      k = 2 * r + 1;
      p = ring_ptr % k;
      nx = (p + r + 1) % k;
      for (int ch = 0; ch < 4; ch++) begin
         old = ring[p][ch];
         mid = (r == 0) ? px[ch] : ring[nx][ch];
         wsum[ch] = wsum[ch] - outsum[ch] + insum[ch] + px[ch];
         outsum[ch] = outsum[ch] - old + mid;
         insum[ch] = insum[ch] + px[ch] - mid;
         ring[p][ch] = px[ch];
      end
      ring_ptr = (p + 1) % k;
   endfunction

   function automatic sbr_tb_pkg::blurred_pixel_type blurred_from_sums(int unsigned r,
                                                                      int unsigned w);
      sbr_tb_pkg::blurred_pixel_type bp;
      int unsigned d;
      d = (r + 1) * (r + 1);
      bp.blur_a = sbr_pkg::chan_type'(wsum[0] / d);
      bp.blur_b = sbr_pkg::chan_type'(wsum[1] / d);
      bp.blur_c = sbr_pkg::chan_type'(wsum[2] / d);
      bp.blur_d = sbr_pkg::chan_type'(wsum[3] / d);
      bp.row_end = (out_col == w - 1);
      bp.run_end = 1'b0;
      out_col = (out_col + 1) & 13'h1FFF;
      return bp;
   endfunction

   // Append one predicted pixel at the tail of the queue.
   function automatic void add_blurred(sbr_tb_pkg::blurred_pixel_type bp);
      blurred_queue.insert(blurred_queue.size(), bp);
   endfunction

   // Work out the blurred pixels that one incoming pixel releases.
   function automatic void predict_blur(sbr_pkg::chan_vec_type pix);
      int unsigned w;
      int unsigned r;
      int unsigned k;
      int unsigned c;
      int unsigned px [4];
      int unsigned n;
      int unsigned sw;
      int unsigned so;
      int unsigned si;
      int unsigned wt;
      w = row_width_eff();
      r = radius_eff(w);
      k = 2 * r + 1;
      c = in_col;
      n = 0;
      px[0] = pix[0];
      px[1] = pix[1];
      px[2] = pix[2];
      px[3] = pix[3];
      if (c == 0) begin
         for (int s = 0; s <= r; s++) ring[s] = px;
      end else if (c <= r) begin
         ring[c + r] = px;
      end
      if (c == r) begin
         for (int ch = 0; ch < 4; ch++) begin
            sw = 0;
            so = 0;
            si = 0;
            for (int s = 0; s < k; s++) begin
               wt = (s <= r) ? s + 1 : k - s;
               sw += wt * ring[s][ch];
               if (s <= r) so += ring[s][ch];
               else si += ring[s][ch];
            end
            wsum[ch] = sw;
            outsum[ch] = so;
            insum[ch] = si;
         end
         ring_ptr = 0;
         out_col = 0;
         add_blurred(blurred_from_sums(r, w));
         n++;
      end else if (c > r) begin
         slide_window(px, r);
         add_blurred(blurred_from_sums(r, w));
         n++;
      end
      if (c >= w - 1) begin
         while (out_col <= w - 1 && n < 64) begin
            slide_window(px, r);
            add_blurred(blurred_from_sums(r, w));
            n++;
         end
         clear_row();
      end else begin
         in_col = c + 1;
      end
      if (n > 0) blurred_queue[$].run_end = 1'b1;
   endfunction

   function automatic int unsigned gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // Result side: random stalls and the checker.
   initial begin
      int unsigned g;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         g = rsp_stall_on ? gap_length() : 0;
         if (g != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sbr_tb_pkg::blurred_pixel_type seen;
      sbr_tb_pkg::blurred_pixel_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{rsp_chan.blur_a, rsp_chan.blur_b, rsp_chan.blur_c, rsp_chan.blur_d,
                  rsp_chan.row_end, rsp_chan.run_end};
         if (blurred_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %h", seen);
         end else begin
            want = blurred_queue.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected a=%0d b=%0d c=%0d d=%0d row_end=%0b run_end=%0b",
                           want.blur_a, want.blur_b, want.blur_c, want.blur_d, want.row_end,
                           want.run_end);
                  $display("          got      a=%0d b=%0d c=%0d d=%0d row_end=%0b run_end=%0b",
                           seen.blur_a, seen.blur_b, seen.blur_c, seen.blur_d,
                           seen.row_end, seen.run_end);
               end
            end
         end
      end
   end

   // Send one pixel; the prediction is made at the accepting edge.
   task automatic send_pixel(sbr_pkg::chan_vec_type pix);
      int unsigned g;
      if (sender_gaps_on) begin
         g = gap_length();
         repeat (g) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.chan_a <= pix[0];
      req_chan.chan_b <= pix[1];
      req_chan.chan_c <= pix[2];
      req_chan.chan_d <= pix[3];
      do @(posedge clock); while (!req_chan.ready);
      predict_blur(pix);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic sbr_pkg::chan_vec_type random_pixel();
      sbr_pkg::chan_vec_type pix;
      for (int ch = 0; ch < 4; ch++) pix[ch] = sbr_pkg::chan_type'($urandom_range(0, 255));
      return pix;
   endfunction

   task automatic wait_drained();
      while (blurred_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Register write, only with nothing in flight.
   task automatic write_register(sbr_pkg::csr_idx_type idx, int unsigned value);
      wait_drained();
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= sbr_pkg::csr_data_type'(value);
      do @(posedge clock); while (!csr_chan.ready);
      if (idx == sbr_pkg::CSR_BLUR_RADIUS) radius_reg = value & 6'h3F;
      else if (idx == sbr_pkg::CSR_ROW_WIDTH) width_reg = value & 13'h1FFF;
      clear_row();
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_shape(int unsigned radius, int unsigned width);
      write_register(sbr_pkg::CSR_BLUR_RADIUS, radius);
      write_register(sbr_pkg::CSR_ROW_WIDTH, width);
   endtask

   // Directed: edge values, pass-through widths, radius clamping, zero width.
   task automatic test_directed();
      set_shape(1, 1);
      send_pixel({8'hFF, 8'h00, 8'hFF, 8'h00});
      set_shape(0, 5);
      repeat (5) send_pixel(random_pixel());
      set_shape(2, 5);
      send_pixel('1);
      send_pixel('0);
      send_pixel({8'hAA, 8'h55, 8'hAA, 8'h55});
      send_pixel({8'h55, 8'hAA, 8'h55, 8'hAA});
      send_pixel('1);
      set_shape(63, 2);
      send_pixel('1);
      send_pixel('0);
      set_shape(63, 0);
      send_pixel(random_pixel());
      // A write mid-row abandons that row.
      set_shape(3, 9);
      repeat (4) send_pixel('1);
      write_register(sbr_pkg::CSR_ROW_WIDTH, 7);
      repeat (7) send_pixel(random_pixel());
   endtask

   // Full radius on a row just wide enough, with a saturated width in one short case.
   task automatic test_extremes();
      set_shape(63, 127);
      repeat (127) send_pixel(random_pixel());
      set_shape(63, 8191);
      repeat (5) send_pixel('1);
      set_shape(2, 4096);
      repeat (4) send_pixel(random_pixel());
   endtask

   // Random rows under several shapes, then one drained pause.
   task automatic test_random_rows();
      int unsigned w;
      for (int shape = 0; shape < 9; shape++) begin
         w = $urandom_range(1, 24);
         set_shape($urandom_range(0, 12), w);
         repeat ($urandom_range(1, 2) * w) send_pixel(random_pixel());
      end
      wait_drained();
      set_shape(5, 11);
      repeat (22) send_pixel(random_pixel());
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.chan_a = '0;
      req_chan.chan_b = '0;
      req_chan.chan_c = '0;
      req_chan.chan_d = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = sbr_pkg::CSR_BLUR_RADIUS;
      csr_chan.data = '0;
      radius_reg = 1;
      width_reg = 1;
      clear_row();
      rsp_stall_on = 1'b0;
      sender_gaps_on = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      sender_gaps_on = 1'b1;
      rsp_stall_on = 1'b1;
      test_extremes();
      test_random_rows();
      wait_drained();
      repeat (100) @(negedge clock);
      if (mismatch_count == 0 && blurred_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

`default_nettype wire

>>> sim.f
sv/sbr_pkg.sv
sv/sbr_if.sv
sv/sbr_ram.sv
sv/sbr_div.sv
sv/stack_blur_row_pass_unit.sv
dv/sbr_tb_if.sv
dv/tb.sv
